>>> rtl/e164_country_code_extract_assert.svh
// Assertion macros shared by the country code extractor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef E164_COUNTRY_CODE_EXTRACT_ASSERT_SVH
`define E164_COUNTRY_CODE_EXTRACT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define E164CC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define E164CC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/e164cc_pkg.sv
// Shared types, constants and decode helpers for the country code extractor.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package e164cc_pkg;

    // Digit encodings of the configuration register
    localparam logic [1:0] ENC_BINARY = 2'd0;
    localparam logic [1:0] ENC_BCD    = 2'd1;
    localparam logic [1:0] ENC_UTF8   = 2'd2;
    localparam logic [1:0] ENC_RSVD   = 2'd3;

    localparam logic [2:0]  WIN_DEPTH     = 3'd7;
    localparam logic [7:0]  SKIP_MAX      = 8'hFF;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [15:0] UTF_OFFSET    = 16'hFFD0;
    localparam logic [15:0] ID_MID_MASK   = 16'h0FF0;
    localparam logic [15:0] ID_EXT_PREFIX = 16'h0510;
    localparam logic [15:0] CC_881        = 16'd881;
    localparam logic [15:0] CC_882        = 16'd882;
    localparam logic [15:0] CC_883        = 16'd883;

    typedef struct packed {
        logic [6:0][7:0] win;
        logic [2:0]      held;
        logic [7:0]      skip;
        logic [1:0]      enc;
    } t_snap;

    typedef struct packed {
        logic        truncated;
        logic [7:0]  zero_bytes_skipped;
        logic        id_nondecimal;
        logic [15:0] id_code;
        logic [2:0]  id_digits;
        logic        cc_nondecimal;
        logic [1:0]  cc_digits;
        logic [15:0] cc_value;
    } t_result;

    // Second digits that close a two-digit country code, per leading digit
    function automatic logic [15:0] two_digit_mask(input logic [3:0] lead);
        logic [15:0] m;
        begin
            unique case (lead)
                4'd2:    m = 16'h0081;
                4'd3:    m = 16'h025F;
                4'd4:    m = 16'hFFFB;
                4'd5:    m = 16'hFDFE;
                4'd6:    m = 16'hFC7F;
                4'd8:    m = 16'h0056;
                4'd9:    m = 16'h013F;
                default: m = 16'h0000;
            endcase
            return m;
        end
    endfunction

    function automatic logic [15:0] utf_digit(input logic [7:0] b);
        return {8'h00, b} + UTF_OFFSET;
    endfunction

    function automatic logic [15:0] to_decimal(input logic [15:0] v);
        return 16'(v[3:0]) + 16'(v[7:4]) * 16'd10 + 16'(v[11:8]) * 16'd100
             + 16'(v[15:12]) * 16'd1000;
    endfunction

    function automatic logic nondecimal(input logic [15:0] v);
        return (v[3:0] > 4'd9) || (v[7:4] > 4'd9) || (v[11:8] > 4'd9)
            || (v[15:12] > 4'd9);
    endfunction

endpackage

>>> rtl/e164_country_code_extract.sv
// Path: a result leaves o_m_axis from the result register; its triggering item
//   is first held in the snapshot register, then decoded into the result register.
// Throughput: one input item per cycle, sustained, while the output is taken.
// Reset: i_rst_n synchronous active low; clears the per-number state, empties
//   both stages and sets the encoding to binary. Window bytes are not cleared.
`timescale 1ns / 1ps

module e164_country_code_extract (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: digit encoding
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,     // [1:0] digit_encoding
    // input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata, // [7:0] data_byte
    input  logic        i_s_axis_tlast, // end_of_number
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] cc_value, [17:16] cc_digits, [18] cc_nondecimal,
    // [21:19] id_digits, [37:22] id_code, [38] id_nondecimal,
    // [46:39] zero_bytes_skipped, [47] truncated
    output logic [47:0] o_m_axis_tdata
);
    import e164cc_pkg::*;

    logic       r_enc;
    logic [1:0] r_enc_q;
    logic       snap_valid, snap_ready;
    t_snap      snap;
    t_result    res;

    // Encoding register: always ready; written only while the block is idle is a rule for the user, not enforced here
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_q <= ENC_BINARY;
        end else if (i_cfg_valid) begin
            r_enc_q <= i_cfg_data;
        end
    end

    // Track that a configuration value is held (binary until first write)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc <= 1'b0;
        end else if (i_cfg_valid) begin
            r_enc <= 1'b1;
        end
    end

    // Store significant bytes; hand a snapshot over when a result is due
    e164cc_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enc        (r_enc ? r_enc_q : ENC_BINARY),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .i_eon        (i_s_axis_tlast),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    // Decode the snapshot and hold the result until taken
    e164cc_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_res        (res)
    );

    // Pack result fields, first struct field in the highest bits
    assign o_m_axis_tdata = {res.truncated, res.zero_bytes_skipped, res.id_nondecimal,
                             res.id_code, res.id_digits, res.cc_nondecimal,
                             res.cc_digits, res.cc_value};

endmodule

>>> rtl/e164cc_window.sv
// Byte window: leading zero skip, significant byte store and result trigger.
// Depends on e164cc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "e164_country_code_extract_assert.svh"

module e164cc_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_enc,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data,
    input  logic               i_eon,
    output logic               o_snap_valid,
    input  logic               i_snap_ready,
    output e164cc_pkg::t_snap  o_snap
);
    import e164cc_pkg::*;

    logic [7:0] r_win [7];
    logic [2:0] r_held, n_held;
    logic       r_in_lz;
    logic       r_rg;
    logic [7:0] r_skip, n_skip;
    logic       r_snap_valid;
    t_snap      r_snap, n_snap;
    logic       binary, skip_byte, store, fire, accept;

    assign o_ready = !r_snap_valid || i_snap_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        binary    = (i_enc == ENC_BINARY) || (i_enc == ENC_RSVD);
        skip_byte = !r_rg && binary && r_in_lz && (i_data == 8'h00);
        store     = !r_rg && !skip_byte && (r_held < WIN_DEPTH);
        n_held    = store ? r_held + 3'd1 : r_held;
        n_skip    = (skip_byte && r_skip != SKIP_MAX) ? r_skip + 8'd1 : r_skip;
        fire      = !r_rg && ((n_held == WIN_DEPTH) || i_eon);
        for (int i = 0; i < 7; i++) begin
            n_snap.win[i] = (store && r_held == 3'(i)) ? i_data : r_win[i];
        end
        n_snap.held = n_held;
        n_snap.skip = n_skip;
        n_snap.enc  = i_enc;
    end

    // Window entries past the fill count are never read
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_win[r_held] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 3'd0;
            r_in_lz <= 1'b1;
            r_rg    <= 1'b0;
            r_skip  <= 8'd0;
        end else if (accept) begin
            if (i_eon) begin
                r_held  <= 3'd0;
                r_in_lz <= 1'b1;
                r_rg    <= 1'b0;
                r_skip  <= 8'd0;
            end else begin
                r_held  <= n_held;
                r_in_lz <= store ? 1'b0 : r_in_lz;
                r_rg    <= r_rg || fire;
                r_skip  <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (accept && fire) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && fire) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    `E164CC_ASSERT(a_given_means_full, i_clk, i_rst_n, r_rg, r_held == WIN_DEPTH, "result given with window not full")
    `E164CC_ASSERT(a_lz_cleared_by_store, i_clk, i_rst_n, !r_in_lz, r_held != 3'd0, "leading zero phase left without a stored byte")
    `E164CC_ASSERT_NEXT(a_fire_loads_snap, i_clk, i_rst_n, accept && fire, r_snap_valid, "trigger did not load the snapshot")

endmodule

>>> rtl/e164cc_decode.sv
// Country code and identification code decode with the result register.
// Depends on e164cc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "e164_country_code_extract_assert.svh"

module e164cc_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_snap_valid,
    output logic                 o_snap_ready,
    input  e164cc_pkg::t_snap    i_snap,
    output logic                 o_valid,
    input  logic                 i_ready,
    output e164cc_pkg::t_result  o_res
);
    import e164cc_pkg::*;

    logic [1:0]  enc;
    logic [7:0]  g    [7];
    logic        miss [7];
    logic [15:0] uf   [7];
    logic [2:0]  idx  [4];
    logic [15:0] ul   [4];
    logic        ulm  [4];
    logic [15:0] cc_raw, cc_sh, id_raw, d;
    logic [15:0] closers;
    logic [3:0]  a, s;
    logic [1:0]  len;
    logic [2:0]  idn;
    logic        trunc;
    t_result     n_res, r_res;
    logic        r_valid;

    always_comb begin
        enc   = (i_snap.enc == ENC_RSVD) ? ENC_BINARY : i_snap.enc;
        trunc = 1'b0;
        for (int i = 0; i < 7; i++) begin
            miss[i] = !(3'(i) < i_snap.held);
            g[i]    = !miss[i] ? i_snap.win[i] : ((enc == ENC_UTF8) ? CHAR_ZERO : 8'h00);
            uf[i]   = utf_digit(g[i]);
        end

        unique case (enc)
            ENC_BINARY: begin
                cc_raw = {g[0], g[1]};
                if (g[0][7:4] != 4'h0) begin
                    cc_raw = cc_raw >> 4;
                end
                trunc = miss[0] || miss[1];
            end
            ENC_BCD: begin
                // a missing second byte reads as zero without truncation
                cc_raw = {4'h0, g[0][3:0], g[0][7:4],
                          (i_snap.held > 3'd1) ? i_snap.win[1][3:0] : 4'h0};
                trunc  = miss[0];
            end
            default: begin
                cc_raw = {uf[0][7:0], 8'h00} | {uf[1][11:0], 4'h0} | uf[2];
                trunc  = miss[0] || miss[1] || miss[2];
            end
        endcase

        a       = cc_raw[11:8];
        s       = cc_raw[7:4];
        closers = two_digit_mask(a);
        if (a == 4'd0 || a == 4'd1 || a == 4'd7) begin
            len = 2'd1;
        end else if (a > 4'd9) begin
            len = 2'd0;
        end else begin
            len = closers[s] ? 2'd2 : 2'd3;
        end

        case (len)
            2'd1:    cc_sh = cc_raw >> 8;
            2'd2:    cc_sh = cc_raw >> 4;
            default: cc_sh = cc_raw;
        endcase
        n_res.cc_value      = to_decimal(cc_sh);
        n_res.cc_nondecimal = nondecimal(cc_sh);
        n_res.cc_digits     = len;

        // UTF-8 digits after the country code
        for (int k = 0; k < 4; k++) begin
            idx[k] = {1'b0, len} + 3'(k);
            ul[k]  = uf[idx[k]];
            ulm[k] = miss[idx[k]];
        end

        idn    = 3'd0;
        id_raw = 16'h0000;
        d      = 16'h0000;
        n_res.id_code       = 16'h0000;
        n_res.id_nondecimal = 1'b0;
        if (n_res.cc_value == CC_881) begin
            idn = 3'd1;
            unique case (enc)
                ENC_BINARY: begin
                    id_raw = {12'h000, g[1][3:0]};
                    trunc  = trunc || miss[1];
                end
                ENC_BCD: begin
                    id_raw = {12'h000, g[1][7:4]};
                    trunc  = trunc || miss[1];
                end
                default: begin
                    id_raw = ul[0];
                    trunc  = trunc || ulm[0];
                end
            endcase
            n_res.id_code       = id_raw;
            n_res.id_nondecimal = id_raw > 16'd9;
        end else if (n_res.cc_value == CC_882 || n_res.cc_value == CC_883) begin
            trunc = trunc || miss[1] || miss[2];
            if (n_res.cc_value == CC_882) begin
                idn = 3'd2;
                unique case (enc)
                    ENC_BINARY: id_raw = {8'h00, g[1][3:0], g[2][7:4]};
                    ENC_BCD:    id_raw = {8'h00, g[1][7:4], g[2][3:0]};
                    default: begin
                        id_raw = {ul[0][11:0], 4'h0} | ul[1];
                        trunc  = trunc || ulm[0] || ulm[1];
                    end
                endcase
            end else begin
                idn = 3'd3;
                unique case (enc)
                    ENC_BINARY: id_raw = {4'h0, g[1][3:0], g[2]};
                    ENC_BCD:    id_raw = {4'h0, g[1][7:4], g[2][3:0], g[2][7:4]};
                    default: begin
                        id_raw = {ul[0][7:0], 8'h00} | {ul[1][11:0], 4'h0} | ul[2];
                        trunc  = trunc || ulm[0] || ulm[1] || ulm[2];
                    end
                endcase
                // 51x takes a fourth digit
                if ((id_raw & ID_MID_MASK) == ID_EXT_PREFIX) begin
                    idn = 3'd4;
                    unique case (enc)
                        ENC_BINARY: begin
                            d     = {12'h000, g[3][7:4]};
                            trunc = trunc || miss[3];
                        end
                        ENC_BCD: begin
                            d     = {12'h000, g[3][3:0]};
                            trunc = trunc || miss[3];
                        end
                        default: begin
                            d     = ul[3];
                            trunc = trunc || ulm[3];
                        end
                    endcase
                    id_raw = {id_raw[11:0], 4'h0} | d;
                end
            end
            n_res.id_code       = to_decimal(id_raw);
            n_res.id_nondecimal = nondecimal(id_raw);
        end
        n_res.id_digits          = idn;
        n_res.zero_bytes_skipped = i_snap.skip;
        n_res.truncated          = trunc;
    end

    assign o_snap_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_snap_ready) begin
            r_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_ready && i_snap_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `E164CC_ASSERT(a_no_len_is_bad, i_clk, i_rst_n, r_valid && r_res.cc_digits == 2'd0, r_res.cc_nondecimal, "undecodable lead digit without nondecimal flag")
    `E164CC_ASSERT(a_no_id_is_clear, i_clk, i_rst_n, r_valid && r_res.id_digits == 3'd0, r_res.id_code == 16'h0000 && !r_res.id_nondecimal, "identification fields set without a code")
    `E164CC_ASSERT_NEXT(a_res_held_stalled, i_clk, i_rst_n, r_valid && !i_ready, r_valid, "result dropped while stalled")

endmodule
